>>> rtl/core/fsgb_pkg.sv
// fsgb_pkg: shared types, register indexes and constants of the fall / sos / gas
// buzzer alarm sequencer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fsgb_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int NOW_W         = 32;
    localparam int MS_W          = 16;
    localparam int MOTION_W      = 7;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    // injury pattern edges: sum of up to four 16 bit lengths
    localparam int PAT_W         = 18;

    // fixed gas beep-beep pattern, in ms from cycle start
    localparam logic [MS_W-1:0] GAS_ON1_END   = 16'd200;
    localparam logic [MS_W-1:0] GAS_ON2_BEGIN = 16'd300;
    localparam logic [MS_W-1:0] GAS_ON2_END   = 16'd500;
    localparam logic [MS_W-1:0] GAS_CYCLE     = 16'd1000;

    // register reset values
    localparam logic [MS_W-1:0]     FAST_TOGGLE_RST  = 16'd60;
    localparam logic [MS_W-1:0]     PAT_BEEP_RST     = 16'd300;
    localparam logic [MS_W-1:0]     PAT_GAP_RST      = 16'd200;
    localparam logic [MS_W-1:0]     PAT_REST_RST     = 16'd1000;
    localparam logic [MOTION_W-1:0] STILL_LIMIT_RST  = 7'd10;
    localparam logic [MS_W-1:0]     STILL_CONFIRM_RST = 16'd2000;
    localparam logic [MS_W-1:0]     ALERT_HOLD_RST   = 16'd5000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FAST_TOGGLE   = 3'd0,
        CFG_PAT_BEEP      = 3'd1,
        CFG_PAT_GAP       = 3'd2,
        CFG_PAT_REST      = 3'd3,
        CFG_STILL_LIMIT   = 3'd4,
        CFG_STILL_CONFIRM = 3'd5,
        CFG_ALERT_HOLD    = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [MS_W-1:0]     fast_toggle_ms;
        logic [MS_W-1:0]     pattern_beep_ms;
        logic [MS_W-1:0]     pattern_gap_ms;
        logic [MS_W-1:0]     pattern_rest_ms;
        logic [MOTION_W-1:0] still_motion_limit;
        logic [MS_W-1:0]     still_confirm_ms;
        logic [MS_W-1:0]     alert_hold_ms;
    } cfg_t;

    typedef struct packed {
        logic [NOW_W-1:0]    now_ms;
        logic                fallen;
        logic [MOTION_W-1:0] motion_level;
        logic                sos_button;
        logic                risk_update;
        logic                red_level;
        logic                gas_anomaly;
    } item_t;

    typedef struct packed {
        logic buzzer_on;
        logic alarm_flag;
        logic immobile_flag;
        logic sos_flag;
        logic gas_flag;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/core/fsgb_cfg.sv
// fsgb_cfg: configuration register file, write only, reset to default timings
// depends on fsgb_pkg
`timescale 1ns / 1ps
`default_nettype none

module fsgb_cfg (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [fsgb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fsgb_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output fsgb_pkg::cfg_t                       cfg
);
    import fsgb_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fast_toggle_ms     <= FAST_TOGGLE_RST;
            cfg_reg.pattern_beep_ms    <= PAT_BEEP_RST;
            cfg_reg.pattern_gap_ms     <= PAT_GAP_RST;
            cfg_reg.pattern_rest_ms    <= PAT_REST_RST;
            cfg_reg.still_motion_limit <= STILL_LIMIT_RST;
            cfg_reg.still_confirm_ms   <= STILL_CONFIRM_RST;
            cfg_reg.alert_hold_ms      <= ALERT_HOLD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_FAST_TOGGLE:   cfg_reg.fast_toggle_ms     <= cfg_wdata;
                CFG_PAT_BEEP:      cfg_reg.pattern_beep_ms    <= cfg_wdata;
                CFG_PAT_GAP:       cfg_reg.pattern_gap_ms     <= cfg_wdata;
                CFG_PAT_REST:      cfg_reg.pattern_rest_ms    <= cfg_wdata;
                CFG_STILL_LIMIT:   cfg_reg.still_motion_limit <= cfg_wdata[MOTION_W-1:0];
                CFG_STILL_CONFIRM: cfg_reg.still_confirm_ms   <= cfg_wdata;
                CFG_ALERT_HOLD:    cfg_reg.alert_hold_ms      <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/core/fsgb_core.sv
// fsgb_core: alarm state registers and the one-tick update logic
// depends on fsgb_pkg
`timescale 1ns / 1ps
`default_nettype none

module fsgb_core #(
    parameter int TIME_BITS = fsgb_pkg::TIME_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  fsgb_pkg::item_t  item,
    input  fsgb_pkg::cfg_t   cfg,
    output fsgb_pkg::result_t res
);
    import fsgb_pkg::*;

    localparam int CW = (TIME_BITS > PAT_W) ? TIME_BITS : PAT_W;

    typedef logic [TIME_BITS-1:0] tm_t;

    // state
    logic sos_latched_reg, gas_latched_reg, still_confirmed_reg, still_timing_reg;
    logic siren_running_reg, pin_level_reg, alarm_state_reg;
    logic gas_cycle_valid_reg, injury_cycle_valid_reg;
    tm_t  sos_start_reg, gas_start_reg, still_start_reg, last_toggle_reg;
    tm_t  gas_cycle_start_reg, injury_cycle_start_reg;

    logic sos_latched_next, gas_latched_next, still_confirmed_next, still_timing_next;
    logic siren_running_next, pin_level_next, alarm_state_next;
    logic gas_cycle_valid_next, injury_cycle_valid_next;
    tm_t  sos_start_next, gas_start_next, still_start_next, last_toggle_next;
    tm_t  gas_cycle_start_next, injury_cycle_start_next;

    tm_t now;
    tm_t hold_t, confirm_t, toggle_t;
    tm_t sos_el, gas_hold_el, still_el, toggle_el, gas_base, gas_el, inj_base, inj_el;
    logic [PAT_W-1:0] e1, e2, e3, e4;
    logic [CW-1:0]    inj_el_w;
    logic gas_case, off_case, fast_case;

    // timestamp reduced or widened to the time width
    generate
        if (TIME_BITS > NOW_W)
        begin : g_wide
            assign now = {{(TIME_BITS-NOW_W){1'b0}}, item.now_ms};
        end
        else if (TIME_BITS == NOW_W)
        begin : g_same
            assign now = item.now_ms;
        end
        else
        begin : g_narrow
            assign now = item.now_ms[TIME_BITS-1:0];
        end
    endgenerate

    assign hold_t    = TIME_BITS'(cfg.alert_hold_ms);
    assign confirm_t = TIME_BITS'(cfg.still_confirm_ms);
    assign toggle_t  = TIME_BITS'(cfg.fast_toggle_ms);

    assign e1 = PAT_W'(cfg.pattern_beep_ms);
    assign e2 = e1 + PAT_W'(cfg.pattern_gap_ms);
    assign e3 = e2 + PAT_W'(cfg.pattern_beep_ms);
    assign e4 = e3 + PAT_W'(cfg.pattern_rest_ms);

    always_comb
    begin
        // sos latch set, then expiry
        sos_latched_next = sos_latched_reg | item.sos_button;
        sos_start_next   = (item.sos_button && !sos_latched_reg) ? now : sos_start_reg;
        sos_el           = now - sos_start_next;
        if (sos_latched_next && (sos_el >= hold_t))
            sos_latched_next = 1'b0;

        // immobility after a fall
        still_confirmed_next = still_confirmed_reg;
        still_timing_next    = still_timing_reg;
        still_start_next     = still_start_reg;
        still_el             = now - still_start_reg;
        if (!item.fallen || (item.motion_level >= cfg.still_motion_limit))
        begin
            still_confirmed_next = 1'b0;
            still_timing_next    = 1'b0;
            still_start_next     = '0;
        end
        else if (!still_timing_reg)
        begin
            still_timing_next = 1'b1;
            still_start_next  = now;
        end
        else if (still_el >= confirm_t)
        begin
            still_confirmed_next = 1'b1;
        end

        // gas latch expiry
        gas_hold_el      = now - gas_start_reg;
        gas_latched_next = gas_latched_reg && !(gas_hold_el >= hold_t);
        gas_start_next   = gas_start_reg;

        // buzzer priority
        gas_case  = !sos_latched_next && gas_latched_next && !item.fallen;
        off_case  = !sos_latched_next && !gas_case && !item.fallen;
        fast_case = sos_latched_next || (item.fallen && !still_confirmed_next);

        siren_running_next      = siren_running_reg;
        pin_level_next          = pin_level_reg;
        last_toggle_next        = last_toggle_reg;
        alarm_state_next        = alarm_state_reg;
        gas_cycle_valid_next    = gas_cycle_valid_reg;
        gas_cycle_start_next    = gas_cycle_start_reg;
        injury_cycle_valid_next = injury_cycle_valid_reg;
        injury_cycle_start_next = injury_cycle_start_reg;

        toggle_el = now - last_toggle_reg;
        gas_base  = gas_cycle_valid_reg ? gas_cycle_start_reg : now;
        gas_el    = now - gas_base;
        inj_base  = injury_cycle_valid_reg ? injury_cycle_start_reg : now;
        inj_el    = now - inj_base;
        inj_el_w  = CW'(inj_el);

        if (off_case)
        begin
            alarm_state_next   = 1'b0;
            siren_running_next = 1'b0;
            pin_level_next     = 1'b0;
        end
        else
        begin
            alarm_state_next = 1'b1;
            if (!siren_running_reg)
            begin
                // siren start tick: pin high, no pattern evaluated
                siren_running_next = 1'b1;
                last_toggle_next   = now;
                pin_level_next     = 1'b1;
            end
            else if (fast_case)
            begin
                if (toggle_el >= toggle_t)
                begin
                    last_toggle_next = now;
                    pin_level_next   = !pin_level_reg;
                end
            end
            else if (gas_case)
            begin
                gas_cycle_valid_next = 1'b1;
                if (gas_el >= TIME_BITS'(GAS_CYCLE))
                begin
                    gas_cycle_start_next = now;
                    pin_level_next       = 1'b1;
                end
                else
                begin
                    gas_cycle_start_next = gas_base;
                    pin_level_next = (gas_el < TIME_BITS'(GAS_ON1_END)) ||
                                     ((gas_el >= TIME_BITS'(GAS_ON2_BEGIN)) &&
                                      (gas_el < TIME_BITS'(GAS_ON2_END)));
                end
            end
            else
            begin
                injury_cycle_valid_next = 1'b1;
                if (inj_el_w >= CW'(e4))
                begin
                    // restart: elapsed is zero, pin high only for a nonzero beep
                    injury_cycle_start_next = now;
                    pin_level_next = (e1 != '0) || ((e2 == '0) && (e3 != '0));
                end
                else
                begin
                    injury_cycle_start_next = inj_base;
                    pin_level_next = (inj_el_w < CW'(e1)) ||
                                     ((inj_el_w >= CW'(e2)) && (inj_el_w < CW'(e3)));
                end
            end
        end

        // risk sample
        if (item.risk_update)
        begin
            if (item.gas_anomaly && !gas_latched_next)
            begin
                gas_latched_next = 1'b1;
                gas_start_next   = now;
            end
            if (!item.fallen && !sos_latched_next && !gas_latched_next)
                alarm_state_next = item.red_level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sos_latched_reg        <= 1'b0;
            gas_latched_reg        <= 1'b0;
            still_confirmed_reg    <= 1'b0;
            still_timing_reg       <= 1'b0;
            siren_running_reg      <= 1'b0;
            pin_level_reg          <= 1'b0;
            alarm_state_reg        <= 1'b0;
            gas_cycle_valid_reg    <= 1'b0;
            injury_cycle_valid_reg <= 1'b0;
            sos_start_reg          <= '0;
            gas_start_reg          <= '0;
            still_start_reg        <= '0;
            last_toggle_reg        <= '0;
            gas_cycle_start_reg    <= '0;
            injury_cycle_start_reg <= '0;
        end
        else if (step)
        begin
            sos_latched_reg        <= sos_latched_next;
            gas_latched_reg        <= gas_latched_next;
            still_confirmed_reg    <= still_confirmed_next;
            still_timing_reg       <= still_timing_next;
            siren_running_reg      <= siren_running_next;
            pin_level_reg          <= pin_level_next;
            alarm_state_reg        <= alarm_state_next;
            gas_cycle_valid_reg    <= gas_cycle_valid_next;
            injury_cycle_valid_reg <= injury_cycle_valid_next;
            sos_start_reg          <= sos_start_next;
            gas_start_reg          <= gas_start_next;
            still_start_reg        <= still_start_next;
            last_toggle_reg        <= last_toggle_next;
            gas_cycle_start_reg    <= gas_cycle_start_next;
            injury_cycle_start_reg <= injury_cycle_start_next;
        end
    end

    assign res.buzzer_on     = pin_level_next;
    assign res.alarm_flag    = alarm_state_next;
    assign res.immobile_flag = still_confirmed_next;
    assign res.sos_flag      = sos_latched_next;
    assign res.gas_flag      = gas_latched_next;

endmodule

`default_nettype wire

>>> rtl/core/fall_sos_gas_buzzer_alarm_sequencer.sv
// fall_sos_gas_buzzer_alarm_sequencer: top level with input and result registers
// depends on fsgb_pkg, fsgb_cfg, fsgb_core
//
// usage:
//   each tick request enters on the in channel (in_valid / in_ready) with a
//   millisecond timestamp, the fall flag, motion level, sos button and an
//   optional risk sample; one result per tick leaves on the out channel
//   (out_valid / out_ready) with buzzer drive, alarm, immobility and latch flags
//   path: an accepted request waits in the input register until the result
//   register is empty or being drained, then its update lands in the result
//   register, where the receiver can take it
//   throughput: one request per cycle while out_ready stays high; the whole
//   tick update is one pass of compare and subtract logic between the input
//   and result registers, and state and result registers load at the same edge
//   stall: when out_ready is low the result register holds; the input register
//   still takes one more request, and in_ready drops only while both the input
//   and result registers are full
//   configuration: cfg_we writes register cfg_index with cfg_wdata;
//   write only while no request is in flight
//   reset: rst_n clears both registers' valid flags, all alarm state, and puts
//   the timing registers at their default values
`timescale 1ns / 1ps
`default_nettype none

module fall_sos_gas_buzzer_alarm_sequencer #(
    parameter int TIME_BITS = fsgb_pkg::TIME_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration write port
    input  wire logic                            cfg_we,
    input  wire logic [fsgb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fsgb_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // tick requests
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [fsgb_pkg::NOW_W-1:0]      now_ms,
    input  wire logic                            fallen,
    input  wire logic [fsgb_pkg::MOTION_W-1:0]   motion_level,
    input  wire logic                            sos_button,
    input  wire logic                            risk_update,
    input  wire logic                            red_level,
    input  wire logic                            gas_anomaly,
    // results
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 buzzer_on,
    output logic                                 alarm_flag,
    output logic                                 immobile_flag,
    output logic                                 sos_flag,
    output logic                                 gas_flag
);
    import fsgb_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    result_t res_reg;
    result_t step_res;
    logic    in_valid_reg;
    logic    out_valid_reg;
    logic    advance;

    // the tick in the input register is processed when the result register
    // is empty or being drained this cycle
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    fsgb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    fsgb_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (step_res)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.now_ms       <= now_ms;
            item_reg.fallen       <= fallen;
            item_reg.motion_level <= motion_level;
            item_reg.sos_button   <= sos_button;
            item_reg.risk_update  <= risk_update;
            item_reg.red_level    <= red_level;
            item_reg.gas_anomaly  <= gas_anomaly;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= step_res;
    end

    assign out_valid     = out_valid_reg;
    assign buzzer_on     = res_reg.buzzer_on;
    assign alarm_flag    = res_reg.alarm_flag;
    assign immobile_flag = res_reg.immobile_flag;
    assign sos_flag      = res_reg.sos_flag;
    assign gas_flag      = res_reg.gas_flag;

    // a sounding buzzer always comes with the alarm state set
    a_buzzer_alarm: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!res_reg.buzzer_on || res_reg.alarm_flag))
        else $error("buzzer on without alarm state");

    // injury confirmation only on a tick that reports a fall
    a_immobile_fallen: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && step_res.immobile_flag) |-> item_reg.fallen)
        else $error("immobility confirmed without a fall");

    // a processed tick always leaves a result behind
    a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed tick produced no result");

    // both registers full and receiver stalled: no further request taken
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("request taken while pipeline full");

endmodule

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for fall_sos_gas_buzzer_alarm_sequencer, with a per-tick alarm model,
// a queued request driver and a result monitor with its own back-pressure
// depends on fsgb_pkg and the sequencer rtl
module tb;
    import fsgb_pkg::*;

    // shapes of stimulus episodes for the random part
    typedef enum int {EP_FALL, EP_SOS, EP_GAS, EP_QUIET, EP_NOISE, EP_JUMP} episode_t;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
    logic                  in_valid     = 1'b0;
    logic                  in_ready;
    logic [NOW_W-1:0]      now_ms       = '0;
    logic                  fallen       = 1'b0;
    logic [MOTION_W-1:0]   motion_level = '0;
    logic                  sos_button   = 1'b0;
    logic                  risk_update  = 1'b0;
    logic                  red_level    = 1'b0;
    logic                  gas_anomaly  = 1'b0;
    logic                  out_valid;
    logic                  out_ready    = 1'b0;
    logic                  buzzer_on;
    logic                  alarm_flag;
    logic                  immobile_flag;
    logic                  sos_flag;
    logic                  gas_flag;

    fall_sos_gas_buzzer_alarm_sequencer DUT (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // alarm model: register copy and sequencer state, advanced once per
    // accepted tick request
    // ------------------------------------------------------------------
    cfg_t regs = '{FAST_TOGGLE_RST, PAT_BEEP_RST, PAT_GAP_RST, PAT_REST_RST,
                   STILL_LIMIT_RST, STILL_CONFIRM_RST, ALERT_HOLD_RST};

    logic             sos_held   = 1'b0;
    logic             gas_held   = 1'b0;
    logic             still_ok   = 1'b0;
    logic             still_run  = 1'b0;
    logic             siren_on   = 1'b0;
    logic             pin        = 1'b0;
    logic             alarm      = 1'b0;
    logic             gas_cyc_ok = 1'b0;
    logic             inj_cyc_ok = 1'b0;
    logic [NOW_W-1:0] sos_t0     = '0;
    logic [NOW_W-1:0] gas_t0     = '0;
    logic [NOW_W-1:0] still_t0   = '0;
    logic [NOW_W-1:0] toggle_t   = '0;
    logic [NOW_W-1:0] gas_cyc_t0 = '0;
    logic [NOW_W-1:0] inj_cyc_t0 = '0;

    // siren start: pin goes high on the first beeping tick, no pattern then
    function automatic logic siren_kick(logic [NOW_W-1:0] t);
        if (siren_on)
            return 1'b0;
        siren_on = 1'b1;
        toggle_t = t;
        pin      = 1'b1;
        return 1'b1;
    endfunction

    function automatic void fast_beep(logic [NOW_W-1:0] t);
        logic [NOW_W-1:0] dt;
        alarm = 1'b1;
        if (siren_kick(t))
            return;
        dt = t - toggle_t;
        if (dt >= regs.fast_toggle_ms)
        begin
            toggle_t = t;
            pin      = !pin;
        end
    endfunction

    function automatic result_t alarm_outputs_after_tick(item_t tk);
        logic [NOW_W-1:0] t;
        logic [NOW_W-1:0] el;
        logic [NOW_W-1:0] e1;
        logic [NOW_W-1:0] e2;
        logic [NOW_W-1:0] e3;
        logic [NOW_W-1:0] e4;
        result_t          r;
        t = tk.now_ms;

        // sos latch set, then expiry (zero hold clears on the same tick)
        if (tk.sos_button && !sos_held)
        begin
            sos_held = 1'b1;
            sos_t0   = t;
        end
        el = t - sos_t0;
        if (sos_held && el >= regs.alert_hold_ms)
            sos_held = 1'b0;

        // immobility: timing starts on the first low-motion tick after a fall
        if (!tk.fallen || tk.motion_level >= regs.still_motion_limit)
        begin
            still_ok  = 1'b0;
            still_run = 1'b0;
            still_t0  = '0;
        end
        else if (!still_run)
        begin
            still_run = 1'b1;
            still_t0  = t;
        end
        else
        begin
            el = t - still_t0;
            if (el >= regs.still_confirm_ms)
                still_ok = 1'b1;
        end

        el = t - gas_t0;
        if (gas_held && el >= regs.alert_hold_ms)
            gas_held = 1'b0;

        // buzzer by priority
        if (sos_held)
            fast_beep(t);
        else if (gas_held && !tk.fallen)
        begin
            alarm = 1'b1;
            if (!siren_kick(t))
            begin
                // cycle start stays armed across episodes
                if (!gas_cyc_ok)
                begin
                    gas_cyc_ok = 1'b1;
                    gas_cyc_t0 = t;
                end
                el = t - gas_cyc_t0;
                if (el >= GAS_CYCLE)
                begin
                    gas_cyc_t0 = t;
                    el         = '0;
                end
                pin = (el < GAS_ON1_END) || (el >= GAS_ON2_BEGIN && el < GAS_ON2_END);
            end
        end
        else if (!tk.fallen)
        begin
            alarm = 1'b0;
            if (siren_on)
            begin
                siren_on = 1'b0;
                pin      = 1'b0;
            end
        end
        else if (!still_ok)
            fast_beep(t);
        else
        begin
            alarm = 1'b1;
            if (!siren_kick(t))
            begin
                if (!inj_cyc_ok)
                begin
                    inj_cyc_ok = 1'b1;
                    inj_cyc_t0 = t;
                end
                el = t - inj_cyc_t0;
                e1 = NOW_W'(regs.pattern_beep_ms);
                e2 = e1 + regs.pattern_gap_ms;
                e3 = e2 + regs.pattern_beep_ms;
                e4 = e3 + regs.pattern_rest_ms;
                if (el >= e4)
                begin
                    inj_cyc_t0 = t;
                    el         = '0;
                end
                pin = (el < e1) || (el >= e2 && el < e3);
            end
        end

        // risk sample comes last: gas latch, then red level when nothing else is active
        if (tk.risk_update)
        begin
            if (tk.gas_anomaly && !gas_held)
            begin
                gas_held = 1'b1;
                gas_t0   = t;
            end
            if (!tk.fallen && !sos_held && !gas_held)
                alarm = tk.red_level;
        end

        r.buzzer_on     = pin;
        r.alarm_flag    = alarm;
        r.immobile_flag = still_ok;
        r.sos_flag      = sos_held;
        r.gas_flag      = gas_held;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // request driver and result monitor
    // ------------------------------------------------------------------
    item_t       pending_ticks[$];
    result_t     expected_outputs[$];
    int unsigned ticks_queued = 0;
    int unsigned results_seen = 0;
    int unsigned ticks_taken  = 0;
    int unsigned mismatch_cnt = 0;
    logic        calm;

    // a stretch of requests where neither side idles
    assign calm = (ticks_taken >= 420) && (ticks_taken < 560);

    always @(posedge clk)
    begin
        item_t taken;
        item_t nx;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                taken = item_t'{now_ms, fallen, motion_level, sos_button,
                                risk_update, red_level, gas_anomaly};
                expected_outputs.push_back(alarm_outputs_after_tick(taken));
                ticks_taken <= ticks_taken + 1;
            end
            // payload only moves once the current request is gone
            if (!in_valid || in_ready)
            begin
                if (pending_ticks.size() != 0 && (calm || $urandom_range(99) >= 20))
                begin
                    nx = pending_ticks.pop_front();
                    in_valid     <= 1'b1;
                    now_ms       <= nx.now_ms;
                    fallen       <= nx.fallen;
                    motion_level <= nx.motion_level;
                    sos_button   <= nx.sos_button;
                    risk_update  <= nx.risk_update;
                    red_level    <= nx.red_level;
                    gas_anomaly  <= nx.gas_anomaly;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    task automatic check_field(string name, logic want, logic got);
        if (got !== want)
        begin
            $error("%s: expected %0b, got %0b", name, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen <= results_seen + 1;
                if (expected_outputs.size() == 0)
                begin
                    $error("result with no tick request waiting");
                    mismatch_cnt++;
                end
                else
                begin
                    want = expected_outputs.pop_front();
                    check_field("buzzer_on", want.buzzer_on, buzzer_on);
                    check_field("alarm_flag", want.alarm_flag, alarm_flag);
                    check_field("immobile_flag", want.immobile_flag, immobile_flag);
                    check_field("sos_flag", want.sos_flag, sos_flag);
                    check_field("gas_flag", want.gas_flag, gas_flag);
                end
            end
            out_ready <= calm || ($urandom_range(99) >= 20);
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    logic [NOW_W-1:0] sim_ms = '0;

    // advance the timestamp and queue one tick request
    task automatic send_tick(int unsigned stp, bit f, int unsigned mot, bit sos,
                             bit risk, bit red, bit gas);
        sim_ms = sim_ms + stp;
        pending_ticks.push_back(item_t'{sim_ms, f, MOTION_W'(mot), sos, risk, red, gas});
        ticks_queued++;
    endtask

    // idle point: wait until every queued request has its result back
    task automatic settle();
        wait (results_seen == ticks_queued);
        repeat (4) @(posedge clk);
    endtask

    task automatic put_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic load_regs(cfg_t v);
        put_reg(CFG_FAST_TOGGLE, v.fast_toggle_ms);
        put_reg(CFG_PAT_BEEP, v.pattern_beep_ms);
        put_reg(CFG_PAT_GAP, v.pattern_gap_ms);
        put_reg(CFG_PAT_REST, v.pattern_rest_ms);
        put_reg(CFG_STILL_LIMIT, CFG_DATA_W'(v.still_motion_limit));
        put_reg(CFG_STILL_CONFIRM, v.still_confirm_ms);
        put_reg(CFG_ALERT_HOLD, v.alert_hold_ms);
        cfg_we <= 1'b0;
        regs = v;
    endtask

    function automatic cfg_t random_regs();
        cfg_t v;
        v.fast_toggle_ms     = MS_W'($urandom_range(200, 1));
        v.pattern_beep_ms    = MS_W'($urandom_range(400, 1));
        v.pattern_gap_ms     = MS_W'($urandom_range(300, 0));
        v.pattern_rest_ms    = MS_W'($urandom_range(1000, 0));
        v.still_motion_limit = MOTION_W'($urandom_range(60, 1));
        v.still_confirm_ms   = MS_W'($urandom_range(1500, 0));
        v.alert_hold_ms      = MS_W'($urandom_range(3000, 0));
        return v;
    endfunction

    // random episodes: mostly coherent fall / sos / gas sequences with
    // random content, plus noise and random timestamp jumps
    task automatic run_episodes(int unsigned n, int unsigned step_max);
        int unsigned made;
        int unsigned len;
        int unsigned pick;
        int unsigned still_mot;
        int unsigned stp;
        int unsigned mot;
        bit          f;
        bit          sos;
        bit          risk;
        bit          red;
        bit          gas;
        episode_t    kind;
        made = 0;
        while (made < n)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
                kind = EP_FALL;
            else if (pick < 55)
                kind = EP_SOS;
            else if (pick < 75)
                kind = EP_GAS;
            else if (pick < 85)
                kind = EP_QUIET;
            else if (pick < 95)
                kind = EP_NOISE;
            else
                kind = EP_JUMP;
            len = (kind == EP_JUMP) ? 1 : $urandom_range(40, 6);
            for (int k = 0; k < len; k++)
            begin
                // a motion value below the current immobility limit (zero when the limit is zero), within 0..100
                if (regs.still_motion_limit == 0)
                    still_mot = 0;
                else if (regs.still_motion_limit > 100)
                    still_mot = $urandom_range(100);
                else
                    still_mot = $urandom_range(regs.still_motion_limit - 1);
                stp  = $urandom_range(step_max);
                mot  = $urandom_range(100);
                red  = $urandom_range(1) != 0;
                case (kind)
                    EP_FALL:
                    begin
                        f    = $urandom_range(19) != 0;
                        mot  = ($urandom_range(6) == 0) ? mot : still_mot;
                        sos  = $urandom_range(49) == 0;
                        risk = $urandom_range(7) == 0;
                        gas  = $urandom_range(3) == 0;
                    end
                    EP_SOS:
                    begin
                        f    = $urandom_range(4) == 0;
                        sos  = (k == 0) || ($urandom_range(9) == 0);
                        risk = $urandom_range(5) == 0;
                        gas  = $urandom_range(3) == 0;
                    end
                    EP_GAS:
                    begin
                        f    = $urandom_range(5) == 0;
                        mot  = ($urandom_range(1) == 0) ? mot : still_mot;
                        sos  = $urandom_range(29) == 0;
                        risk = (k == 0) || ($urandom_range(5) == 0);
                        gas  = (k == 0) || ($urandom_range(1) == 0);
                    end
                    EP_QUIET:
                    begin
                        f    = 1'b0;
                        sos  = 1'b0;
                        risk = $urandom_range(2) == 0;
                        gas  = $urandom_range(9) == 0;
                    end
                    default:
                    begin
                        // noise, or a jump to an arbitrary timestamp
                        if (kind == EP_JUMP)
                        begin
                            sim_ms = $urandom;
                            stp    = 0;
                        end
                        else
                            stp = $urandom_range(4 * step_max);
                        f    = $urandom_range(1) != 0;
                        sos  = $urandom_range(1) != 0;
                        risk = $urandom_range(1) != 0;
                        gas  = $urandom_range(1) != 0;
                    end
                endcase
                send_tick(stp, f, mot, sos, risk, red, gas);
                made++;
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, reset register values
        send_tick(0, 0, 0, 0, 0, 0, 0);
        // red risk sample raises the alarm flag alone, a clean one drops it
        send_tick(10, 0, 100, 0, 1, 1, 0);
        send_tick(10, 0, 5, 0, 1, 0, 0);
        // sos: siren start, no toggle before the half period, toggle, hold expiry
        send_tick(10, 0, 0, 1, 0, 0, 0);
        send_tick(30, 0, 0, 0, 0, 0, 0);
        send_tick(30, 0, 0, 0, 0, 0, 0);
        send_tick(5000, 0, 0, 0, 0, 0, 0);
        // gas latch, siren start, then walk the beep-beep cycle and its restart
        send_tick(10, 0, 0, 0, 1, 0, 1);
        send_tick(10, 0, 0, 0, 0, 0, 0);
        send_tick(100, 0, 0, 0, 0, 0, 0);
        send_tick(250, 0, 0, 0, 0, 0, 0);
        send_tick(100, 0, 0, 0, 0, 0, 0);
        send_tick(700, 0, 0, 0, 0, 0, 0);
        // a fall during gas overrides the beep-beep with fast toggle
        send_tick(10, 1, 50, 0, 0, 0, 0);
        send_tick(5000, 0, 0, 0, 0, 0, 0);
        // fall, immobility timing from the first still tick, confirm, injury pattern
        send_tick(10, 1, 0, 0, 0, 0, 0);
        send_tick(1000, 1, 9, 0, 0, 0, 0);
        send_tick(1000, 1, 9, 0, 1, 1, 1);
        send_tick(250, 1, 0, 0, 0, 0, 0);
        send_tick(100, 1, 0, 0, 0, 0, 0);
        send_tick(200, 1, 0, 0, 0, 0, 0);
        send_tick(1300, 1, 0, 0, 0, 0, 0);
        // motion at the limit clears immobility
        send_tick(10, 1, 10, 0, 0, 0, 0);
        // timestamp wrap during sos fast toggle
        sim_ms = 32'hFFFF_FFF0;
        send_tick(0, 0, 100, 1, 0, 0, 0);
        send_tick(32, 0, 64, 0, 0, 0, 0);
        send_tick(40, 0, 63, 0, 0, 0, 0);
        settle();

        // low extremes: one-ms phases, empty gaps, zero hold and confirm,
        // limit above range so every motion is immobile
        load_regs('{16'd1, 16'd1, 16'd0, 16'd0, 7'd101, 16'd0, 16'd0});
        run_episodes(130, 4);
        settle();

        // high extremes, limit zero so nothing is ever immobile
        load_regs('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd0, 16'hFFFF, 16'hFFFF});
        run_episodes(110, 5000);
        settle();

        load_regs(random_regs());
        run_episodes(150, 60);
        settle();

        // back to reset values; the no-idle stretch covers requests 420 to 559
        load_regs('{FAST_TOGGLE_RST, PAT_BEEP_RST, PAT_GAP_RST, PAT_REST_RST,
                    STILL_LIMIT_RST, STILL_CONFIRM_RST, ALERT_HOLD_RST});
        run_episodes(180, 80);
        settle();

        load_regs(random_regs());
        run_episodes(150, 40);
        settle();

        if (expected_outputs.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_outputs.size());
            mismatch_cnt++;
        end
        if (mismatch_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog: far beyond the slowest correct run
    initial
    begin
        #3_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
